// ----- src/ccf_pkg.sv -----
// ----------------------------------------------------------------------------
// ccf_pkg: shared types and constants for the chat color code filter
// Byte codes, terminal action codes, escape phase type and the result struct.
// ----------------------------------------------------------------------------
package ccf_pkg;

  // Byte codes
  localparam logic [7:0] CH_ESCAPE   = 8'h03;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_VT       = 8'h0B;
  localparam logic [7:0] CH_FF       = 8'h0C;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;
  localparam logic [3:0] DIGIT_ROW   = 4'h3;   // 0x30..0x3F count as digits

  localparam logic [3:0] COLOR_DEFAULT = 4'hF;

  // Terminal actions
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_PRINT = 3'd1;
  localparam logic [2:0] ACT_BS    = 3'd2;
  localparam logic [2:0] ACT_TAB   = 3'd3;
  localparam logic [2:0] ACT_NL    = 3'd4;
  localparam logic [2:0] ACT_VT    = 3'd5;
  localparam logic [2:0] ACT_FF    = 3'd6;
  localparam logic [2:0] ACT_CR    = 3'd7;

  // Escape phase
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,  // outside an escape
    PH_ESC   = 3'd1,  // after 0x03
    PH_FG1   = 3'd2,  // after first color digit
    PH_FG2   = 3'd3,  // after the color
    PH_COMMA = 3'd4,  // after the comma
    PH_BG    = 3'd5   // after first background byte
  } phase_t;

  typedef struct packed {
    logic       color_set;
    logic [3:0] fg_color;
    logic [2:0] action;
    logic [6:0] glyph;
  } result_t;

endpackage

// ----- src/ccf_step.sv -----
// ----------------------------------------------------------------------------
// ccf_step: escape state and per-byte decode
// Holds phase and pending digit; turns one byte into one result item.
// ----------------------------------------------------------------------------
module ccf_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [7:0]       rx_byte,
  output ccf_pkg::result_t res
);

  ccf_pkg::phase_t phase;
  ccf_pkg::phase_t phase_next;
  ccf_pkg::phase_t phase_base;
  logic [7:0]      pending;
  logic [7:0]      pending_next;

  logic       is_digit;
  logic [3:0] digit;
  logic       plain;
  logic [7:0] two_digit;
  logic [7:0] color_val;

  assign is_digit  = (rx_byte[7:4] == ccf_pkg::DIGIT_ROW);
  assign digit     = rx_byte[3:0];
  // pending*10 + digit - 1, 8-bit wrap
  assign two_digit = (pending << 3) + (pending << 1) + {4'd0, digit} - 8'd1;
  assign color_val = is_digit ? two_digit : pending;

  // Next state
  always_comb begin
    phase_base   = phase;
    pending_next = pending;
    plain        = 1'b0;
    unique case (phase)
      ccf_pkg::PH_IDLE: begin
        plain = 1'b1;
      end
      ccf_pkg::PH_ESC: begin
        if (is_digit) begin
          pending_next = {4'd0, digit};
          phase_base   = ccf_pkg::PH_FG1;
        end else begin
          phase_base = ccf_pkg::PH_IDLE;
          plain      = 1'b1;
        end
      end
      ccf_pkg::PH_FG2: begin
        if (rx_byte == ccf_pkg::CH_COMMA) begin
          phase_base = ccf_pkg::PH_COMMA;
        end else begin
          phase_base = ccf_pkg::PH_IDLE;
          plain      = 1'b1;
        end
      end
      ccf_pkg::PH_COMMA: begin
        phase_base = ccf_pkg::PH_BG;
      end
      ccf_pkg::PH_BG: begin
        phase_base = ccf_pkg::PH_IDLE;
        plain      = !is_digit;
      end
      default: begin
        // first color digit seen (spare codes land here too)
        phase_base   = ccf_pkg::phase_t'(3'(phase) + 3'd1);
        pending_next = 8'd0;
        plain        = !is_digit;
      end
    endcase
    // an escape byte handled as plain text bumps the phase once more
    if (plain && rx_byte == ccf_pkg::CH_ESCAPE) begin
      phase_next = ccf_pkg::phase_t'(3'(phase_base) + 3'd1);
    end else begin
      phase_next = phase_base;
    end
  end

  // Outputs
  always_comb begin
    res = '0;
    unique case (phase) inside
      ccf_pkg::PH_IDLE, ccf_pkg::PH_FG2, ccf_pkg::PH_COMMA, ccf_pkg::PH_BG: begin
        res.color_set = 1'b0;
      end
      ccf_pkg::PH_ESC: begin
        if (!is_digit) begin
          res.color_set = 1'b1;
          res.fg_color  = ccf_pkg::COLOR_DEFAULT;
        end
      end
      default: begin
        res.color_set = 1'b1;
        res.fg_color  = (color_val[7:4] == 4'd0) ? color_val[3:0] : ccf_pkg::COLOR_DEFAULT;
      end
    endcase
    if (plain) begin
      case (rx_byte)
        ccf_pkg::CH_ESCAPE: res.action = ccf_pkg::ACT_NONE;
        ccf_pkg::CH_BS:     res.action = ccf_pkg::ACT_BS;
        ccf_pkg::CH_TAB:    res.action = ccf_pkg::ACT_TAB;
        ccf_pkg::CH_NL:     res.action = ccf_pkg::ACT_NL;
        ccf_pkg::CH_VT:     res.action = ccf_pkg::ACT_VT;
        ccf_pkg::CH_FF:     res.action = ccf_pkg::ACT_FF;
        ccf_pkg::CH_CR:     res.action = ccf_pkg::ACT_CR;
        default: begin
          if (rx_byte >= ccf_pkg::CH_PRINT_LO && rx_byte <= ccf_pkg::CH_PRINT_HI) begin
            res.action = ccf_pkg::ACT_PRINT;
            res.glyph  = rx_byte[6:0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= ccf_pkg::PH_IDLE;
      pending <= 8'd0;
    end else if (en) begin
      phase   <= phase_next;
      pending <= pending_next;
    end
  end

endmodule

// ----- src/chat_color_code_filter.sv -----
// ----------------------------------------------------------------------------
// chat_color_code_filter: color escape filter for a received text stream
// Input register, per-byte decode with escape state, result register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall carry one received byte (rx_byte) per
//   item. Output channel: out_valid / out_stall carry one result item per
//   input item: color_set, fg_color, action, glyph.
//   An item is taken at a rising edge with valid high and stall low.
//   Throughput: one item per cycle while the receiver does not stall; the
//   escape phase and pending digit are updated in the same cycle the byte
//   moves from the input register to the result register, so consecutive
//   bytes need no bubble. An item passes the input, then the result register.
//   When the receiver stalls, the result register holds its item; an empty
//   input register still takes one more item, after which in_stall rises.
//   Reset (rst, synchronous) empties both registers and returns the escape
//   state to idle with a cleared pending digit.
// ----------------------------------------------------------------------------
module chat_color_code_filter (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       color_set,
  output logic [3:0] fg_color,
  output logic [2:0] action,
  output logic [6:0] glyph
);

  // input register
  logic       in_full;
  logic [7:0] in_byte;

  // result register
  ccf_pkg::result_t res;
  ccf_pkg::result_t res_reg;

  logic res_open;   // result register can take an item this cycle
  logic advance;    // byte moves from input register to result register

  assign res_open = !out_valid || !out_stall;
  assign advance  = in_full && res_open;
  assign in_stall = in_full && !res_open;

  ccf_step u_step (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .rx_byte (in_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_open) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_reg <= res;
    end
  end

  assign color_set = res_reg.color_set;
  assign fg_color  = res_reg.fg_color;
  assign action    = res_reg.action;
  assign glyph     = res_reg.glyph;

endmodule

// ----- test/tb_chat_color_code_filter.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chat_color_code_filter: self-checking bench for the color code filter
// A queue of text bytes feeds a clocked driver. A clocked monitor keeps its
// own copy of the escape state, predicts one result item per accepted byte
// and checks each result item, field by field, in order. Both sides idle and
// stall at random. Two long receiver holds fill the block and back up its
// input.
// ----------------------------------------------------------------------------
module tb_chat_color_code_filter;

  localparam int ITEM_TOTAL = 1050;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       color_set;
  logic [3:0] fg_color;
  logic [2:0] action;
  logic [6:0] glyph;

  // stimulus bytes not yet offered, and predicted results not yet seen
  logic [7:0]       byte_queue[$];
  ccf_pkg::result_t expected_results[$];

  // predictor copy of the escape state
  logic [2:0] esc_phase = ccf_pkg::PH_IDLE;
  logic [7:0] pend_color = 8'h00;

  int unsigned err_count = 0;
  int unsigned taken_count = 0;
  int unsigned result_count = 0;
  int unsigned stim_total = 0;
  bit          byte_taken = 1'b0;  // set at the edge that takes an item

  // sender gap state
  int unsigned send_gap = 0;

  // receiver stall state
  int unsigned rx_run = 0;
  bit          rx_stalling = 1'b0;
  int unsigned hold_left = 0;
  int unsigned hold_mark = 300;

  chat_color_code_filter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .color_set (color_set),
    .fg_color  (fg_color),
    .action    (action),
    .glyph     (glyph)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Byte seen as plain text: an escape byte opens (or advances) an escape,
  // controls map to cursor actions, printables print, the rest do nothing.
  function automatic logic [2:0] plain_action(input logic [7:0] c, output logic [6:0] g);
    g = '0;
    plain_action = ccf_pkg::ACT_NONE;
    case (c)
      ccf_pkg::CH_ESCAPE: esc_phase = esc_phase + 3'd1;
      ccf_pkg::CH_BS:     plain_action = ccf_pkg::ACT_BS;
      ccf_pkg::CH_TAB:    plain_action = ccf_pkg::ACT_TAB;
      ccf_pkg::CH_NL:     plain_action = ccf_pkg::ACT_NL;
      ccf_pkg::CH_VT:     plain_action = ccf_pkg::ACT_VT;
      ccf_pkg::CH_FF:     plain_action = ccf_pkg::ACT_FF;
      ccf_pkg::CH_CR:     plain_action = ccf_pkg::ACT_CR;
      default: begin
        if (c >= ccf_pkg::CH_PRINT_LO && c <= ccf_pkg::CH_PRINT_HI) begin
          plain_action = ccf_pkg::ACT_PRINT;
          g = c[6:0];
        end
      end
    endcase
  endfunction

  function automatic ccf_pkg::result_t next_filter_result(input logic [7:0] c);
    ccf_pkg::result_t r;
    logic             as_plain;
    logic             digit;
    logic [6:0]       g;
    r = '0;
    as_plain = 1'b0;
    digit = (c[7:4] == ccf_pkg::DIGIT_ROW);  // any of 0x30..0x3F counts as a digit
    case (esc_phase)
      ccf_pkg::PH_IDLE: as_plain = 1'b1;
      ccf_pkg::PH_FG2: begin
        if (c == ccf_pkg::CH_COMMA) begin
          esc_phase = ccf_pkg::PH_COMMA;
        end else begin
          esc_phase = ccf_pkg::PH_IDLE;
          as_plain = 1'b1;
        end
      end
      ccf_pkg::PH_COMMA: esc_phase = ccf_pkg::PH_BG;
      ccf_pkg::PH_BG: begin
        esc_phase = ccf_pkg::PH_IDLE;
        as_plain = !digit;
      end
      ccf_pkg::PH_ESC: begin
        if (digit) begin
          pend_color = {4'h0, c[3:0]};
          esc_phase = ccf_pkg::PH_FG1;
        end else begin
          // no digit after the escape byte: back to the default color
          r.color_set = 1'b1;
          r.fg_color = ccf_pkg::COLOR_DEFAULT;
          esc_phase = ccf_pkg::PH_IDLE;
          as_plain = 1'b1;
        end
      end
      default: begin
        // second color byte; the two unused phase codes land here as well
        if (digit) pend_color = pend_color * 8'd10 + {4'h0, c[3:0]} - 8'd1;
        esc_phase = esc_phase + 3'd1;
        r.color_set = 1'b1;
        r.fg_color = (pend_color < 8'd16) ? pend_color[3:0] : ccf_pkg::COLOR_DEFAULT;
        pend_color = '0;
        as_plain = !digit;
      end
    endcase
    if (as_plain) begin
      r.action = plain_action(c, g);
      r.glyph = g;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // decimal digits mostly, the whole 0x30..0x3F row now and then
  function automatic logic [7:0] rand_digit();
    if ($urandom_range(0, 9) < 7) return 8'h30 + 8'($urandom_range(0, 9));
    return 8'h30 + 8'($urandom_range(0, 15));
  endfunction

  // text: printables with some cursor controls mixed in
  function automatic logic [7:0] rand_text();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(32, 126));
    return ccf_pkg::CH_BS + 8'($urandom_range(0, 5));
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    $display("[%0t] MISMATCH result item %0d: %s", $time, result_count, what);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers the next queued byte after a random gap; valid stays up
  // and the byte stays put until the item is taken.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst && (byte_taken || !in_valid)) begin
      byte_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (byte_queue.size() != 0) begin
        rx_byte <= byte_queue.pop_front();
        in_valid <= 1'b1;
        // quiet stretch in the middle of the run: back to back items
        send_gap = (taken_count >= 500 && taken_count < 650) ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall runs, a quiet stretch, and two long holds that
  // back the block up into its input.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left == 0 && taken_count >= hold_mark) begin
        hold_left = 64;
        hold_mark = hold_mark + 450;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (taken_count >= 500 && taken_count < 650) begin
        out_stall <= 1'b0;
      end else begin
        if (rx_run == 0) begin
          rx_stalling = ($urandom_range(0, 99) < 35);
          rx_run = rx_stalling ? 1 + pick_gap() : 1 + $urandom_range(0, 7);
        end
        rx_run--;
        out_stall <= rx_stalling;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on each accepted byte, checks each accepted result.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    ccf_pkg::result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(next_filter_result(rx_byte));
        taken_count++;
        byte_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (color_set !== want.color_set)
            report_mismatch($sformatf("color_set %0b, want %0b", color_set, want.color_set));
          if (fg_color !== want.fg_color)
            report_mismatch($sformatf("fg_color %0d, want %0d", fg_color, want.fg_color));
          if (action !== want.action)
            report_mismatch($sformatf("action %0d, want %0d", action, want.action));
          if (glyph !== want.glyph)
            report_mismatch($sformatf("glyph 0x%0h, want 0x%0h", glyph, want.glyph));
        end
        result_count++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    int unsigned kind;

    // directed: byte extremes, every action, high bytes that do nothing
    byte_queue = '{8'h00, 8'hFF, 8'h20, 8'h7E, 8'h7F, ccf_pkg::CH_BS, ccf_pkg::CH_TAB,
                   ccf_pkg::CH_NL, ccf_pkg::CH_VT, ccf_pkg::CH_FF, ccf_pkg::CH_CR,
                   8'hE2, 8'hEF};
    // two digit color, comma, background digits swallowed
    byte_queue.push_back(ccf_pkg::CH_ESCAPE);
    byte_queue.push_back("1");
    byte_queue.push_back("2");
    byte_queue.push_back(ccf_pkg::CH_COMMA);
    byte_queue.push_back("3");
    byte_queue.push_back("4");
    // escape followed by a non-digit: default color, byte printed
    byte_queue.push_back(ccf_pkg::CH_ESCAPE);
    byte_queue.push_back("A");
    // "00" wraps below zero and clamps to the default color
    byte_queue.push_back(ccf_pkg::CH_ESCAPE);
    byte_queue.push_back("0");
    byte_queue.push_back("0");
    // single top-row digit, then an escape byte while the color closes
    byte_queue.push_back(ccf_pkg::CH_ESCAPE);
    byte_queue.push_back("?");
    byte_queue.push_back(ccf_pkg::CH_ESCAPE);

    // random: mostly well-formed escapes with random content
    while (byte_queue.size() < ITEM_TOTAL) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        byte_queue.push_back(ccf_pkg::CH_ESCAPE);
        repeat ($urandom_range(1, 2)) byte_queue.push_back(rand_digit());
        if ($urandom_range(0, 2) == 0) begin
          byte_queue.push_back(ccf_pkg::CH_COMMA);
          repeat ($urandom_range(0, 2)) byte_queue.push_back(rand_digit());
        end
        repeat ($urandom_range(0, 4)) byte_queue.push_back(rand_text());
      end else if (kind < 72) begin
        repeat ($urandom_range(1, 6)) byte_queue.push_back(rand_text());
      end else if (kind < 87) begin
        repeat ($urandom_range(1, 4)) byte_queue.push_back(8'($urandom_range(0, 255)));
      end else begin
        // broken escape: doubled escape byte or arbitrary follower
        byte_queue.push_back(ccf_pkg::CH_ESCAPE);
        byte_queue.push_back($urandom_range(0, 1) ? ccf_pkg::CH_ESCAPE
                                                  : 8'($urandom_range(0, 255)));
      end
    end
    stim_total = byte_queue.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // everything taken and answered; the global limit covers a hang
    while (taken_count < stim_total || expected_results.size() != 0) @(negedge clk);
    // keep watching to catch stray result items
    repeat (8) @(negedge clk);

    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // global limit, far above the slowest legal run
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
